// File: rtl/core/rde_pkg.sv
`timescale 1ns / 1ps

package rde_pkg;

   localparam int VALUE_WIDTH = 31;
   // base 2 needs one digit per value bit
   localparam int NUM_DIGITS  = VALUE_WIDTH;
   localparam int DIGIT_W     = 4;
   localparam int BASE_W      = 5;
   localparam int ADDR_W      = 3;
   localparam int DATA_W      = 32;

   // cell i works on the value bits once the enable has passed the i cells below it
   localparam int CONV_CYCLES = VALUE_WIDTH + NUM_DIGITS - 1;
   localparam int CNT_W       = $clog2(CONV_CYCLES);

   localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(CONV_CYCLES - 1);
   localparam logic [CNT_W-1:0] CNT_FEED   = CNT_W'(VALUE_WIDTH);

   localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
   localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
   localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(16);

   localparam logic [ADDR_W-1:0] ADDR_BASE  = ADDR_W'(0);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } rde_state_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } rde_cell_ctrl_type;

endpackage

// File: rtl/core/rde_csr.sv
`timescale 1ns / 1ps

module rde_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [rde_pkg::ADDR_W-1:0]           paddr,
   input  logic [rde_pkg::DATA_W-1:0]           pwdata,
   output logic [rde_pkg::DATA_W-1:0]           prdata,
   output logic                                 pready,
   output logic [rde_pkg::BASE_W-1:0]           eff_base
);

   logic [rde_pkg::BASE_W-1:0] base_ff;
   logic [rde_pkg::BASE_W-1:0] base_in;
   logic                       hit;

   assign hit    = (paddr == rde_pkg::ADDR_BASE);
   assign pready = 1'b1;

   always_comb begin
      base_in = base_ff;
      if (psel && penable && pwrite && hit) begin
         base_in = pwdata[rde_pkg::BASE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= rde_pkg::BASE_RESET;
      end else begin
         base_ff <= base_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (hit) begin
         prdata = {{(rde_pkg::DATA_W-rde_pkg::BASE_W){1'b0}}, base_ff};
      end
   end

   // out-of-range bases clamp to 2 or 16
   always_comb begin
      if (base_ff < rde_pkg::BASE_MIN) begin
         eff_base = rde_pkg::BASE_MIN;
      end else if (base_ff > rde_pkg::BASE_MAX) begin
         eff_base = rde_pkg::BASE_MAX;
      end else begin
         eff_base = base_ff;
      end
   end

endmodule

// File: rtl/core/rde_cell.sv
`timescale 1ns / 1ps

// One base-b digit; clear zeroes it, shift loads digit_upper. Otherwise per enabled cycle:
// digit = 2*digit + carry_in mod b, carry out registered toward the next cell.
module rde_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  rde_pkg::rde_cell_ctrl_type         ctrl,
   input  logic                               en_in,
   input  logic                               carry_in,
   input  logic [rde_pkg::BASE_W-1:0]         base,
   input  logic [rde_pkg::DIGIT_W-1:0]        digit_upper,
   output logic [rde_pkg::DIGIT_W-1:0]        digit,
   output logic                               carry_out,
   output logic                               en_out
);

   logic [rde_pkg::DIGIT_W-1:0] digit_ff;
   logic [rde_pkg::DIGIT_W-1:0] digit_in;
   logic                        carry_out_ff;
   logic                        carry_out_in;
   logic                        en_out_ff;
   logic                        en_out_in;
   logic [rde_pkg::BASE_W-1:0]  dbl;
   logic [rde_pkg::BASE_W-1:0]  red;
   logic                        ge;

   // digit < base, so 2*digit+carry < 2*base: one subtract is enough
   assign dbl = {digit_ff, carry_in};
   assign ge  = (dbl >= base);
   assign red = ge ? (dbl - base) : dbl;

   always_comb begin
      digit_in     = digit_ff;
      carry_out_in = 1'b0;
      en_out_in    = 1'b0;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.shift) begin
         digit_in = digit_upper;
      end else if (en_in) begin
         digit_in     = red[rde_pkg::DIGIT_W-1:0];
         carry_out_in = ge;
         en_out_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_out_ff <= 1'b0;
         en_out_ff    <= 1'b0;
      end else begin
         carry_out_ff <= carry_out_in;
         en_out_ff    <= en_out_in;
      end
   end

   assign digit     = digit_ff;
   assign carry_out = carry_out_ff;
   assign en_out    = en_out_ff;

endmodule

// File: rtl/core/radix_digit_extractor.sv
`timescale 1ns / 1ps

// Channel   Ports                              Direction  Transfer
// req       start, busy, req_value             in         start & !busy
// rsp       rsp_valid, rsp_digit,              out        rsp_valid, one cycle
//           rsp_last_digit
// csr       psel, penable, pwrite, paddr,      in/out     APB write, base at 0x0
//           pwdata, prdata, pready
//
// The value shifts MSB first into a skewed row of digit cells; conversion runs
// until the counter reaches CNT_LAST, so the carry can ripple through the row.
// Digits then leave one per cycle, LSB first, up to the highest nonzero digit.
// Reset: base 10, idle. The receiver cannot stall; busy holds off start.
module radix_digit_extractor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [rde_pkg::VALUE_WIDTH-1:0]      req_value,
   output logic                                 rsp_valid,
   output logic [rde_pkg::DIGIT_W-1:0]          rsp_digit,
   output logic                                 rsp_last_digit,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [rde_pkg::ADDR_W-1:0]           paddr,
   input  logic [rde_pkg::DATA_W-1:0]           pwdata,
   output logic [rde_pkg::DATA_W-1:0]           prdata,
   output logic                                 pready
);

   rde_pkg::rde_state_type             state_ff;
   rde_pkg::rde_state_type             state_in;
   logic [rde_pkg::CNT_W-1:0]          cnt_ff;
   logic [rde_pkg::CNT_W-1:0]          cnt_in;
   logic [rde_pkg::VALUE_WIDTH-1:0]    value_ff;
   logic [rde_pkg::VALUE_WIDTH-1:0]    value_in;
   logic [rde_pkg::BASE_W-1:0]         eff_base;
   rde_pkg::rde_cell_ctrl_type         cell_ctrl;
   logic                               accept;
   logic                               feed_en;
   logic                               upper_nz;

   logic [rde_pkg::DIGIT_W-1:0]        digits [rde_pkg::NUM_DIGITS];
   logic [rde_pkg::DIGIT_W-1:0]        uppers [rde_pkg::NUM_DIGITS];
   logic                               carries[rde_pkg::NUM_DIGITS+1];
   logic                               ens    [rde_pkg::NUM_DIGITS+1];

   rde_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .eff_base (eff_base)
   );

   assign busy    = (state_ff != rde_pkg::ST_IDLE);
   assign accept  = start && !busy;
   assign feed_en = (state_ff == rde_pkg::ST_CONVERT) && (cnt_ff < rde_pkg::CNT_FEED);

   assign cell_ctrl.clear = accept;
   assign cell_ctrl.shift = (state_ff == rde_pkg::ST_EMIT);

   assign carries[0] = value_ff[rde_pkg::VALUE_WIDTH-1];
   assign ens[0]     = feed_en;

   for (genvar i = 0; i < rde_pkg::NUM_DIGITS; i++) begin : g_cell
      if (i == rde_pkg::NUM_DIGITS - 1) begin : g_top
         assign uppers[i] = '0;
      end else begin : g_mid
         assign uppers[i] = digits[i+1];
      end

      rde_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .en_in       (ens[i]),
         .carry_in    (carries[i]),
         .base        (eff_base),
         .digit_upper (uppers[i]),
         .digit       (digits[i]),
         .carry_out   (carries[i+1]),
         .en_out      (ens[i+1])
      );
   end

   // any nonzero digit above the one on the output means more to come
   always_comb begin
      upper_nz = 1'b0;
      for (int i = 1; i < rde_pkg::NUM_DIGITS; i++) begin
         upper_nz = upper_nz | (|digits[i]);
      end
   end

   assign rsp_valid      = (state_ff == rde_pkg::ST_EMIT);
   assign rsp_digit      = digits[0];
   assign rsp_last_digit = !upper_nz;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      value_in = value_ff;
      case (state_ff)
         rde_pkg::ST_IDLE: begin
            if (start) begin
               state_in = rde_pkg::ST_CONVERT;
               cnt_in   = '0;
               value_in = req_value;
            end
         end
         rde_pkg::ST_CONVERT: begin
            cnt_in   = cnt_ff + 1'b1;
            value_in = {value_ff[rde_pkg::VALUE_WIDTH-2:0], 1'b0};
            if (cnt_ff == rde_pkg::CNT_LAST) begin
               state_in = rde_pkg::ST_EMIT;
            end
         end
         rde_pkg::ST_EMIT: begin
            if (!upper_nz) begin
               state_in = rde_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rde_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rde_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule
